### hdl/trd_pkg.sv
// Shared constants, types and helper functions for the triangle raster and depth test block.
// Used by trd_unit and by the top level triangle_raster_depth_test.
package trd_pkg;

   localparam int SCREEN_WIDTH  = 512;
   localparam int SCREEN_HEIGHT = 512;
   localparam int DEPTH_WORDS   = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int DEPTH_AW      = $clog2(DEPTH_WORDS);

   localparam logic [23:0] FAR_DEPTH  = 24'hFFFFFF;
   localparam logic [7:0]  HALF_PIXEL = 8'h80;

   // Width of the shared accumulator and of one multiplier operand.
   localparam int WIDE      = 52;
   localparam int OPW       = 26;
   localparam int MUL_STEPS = 26;
   localparam int DIV_STEPS = 24;
   localparam int CNT_W     = 5;

   typedef struct packed {
      logic            go;
      logic            is_div;
      logic [WIDE-1:0] acc_init;
      logic [WIDE-1:0] addend;
      logic [OPW-1:0]  mult;
   } trd_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } trd_stat_type;

   // Clamps a signed pixel coordinate to 0..size-1 and keeps the 9 bits of the box field.
   function automatic logic [8:0] clamp_pix(input logic signed [17:0] v, input int size);
      logic [8:0] r;
      if (v < 0) begin
         r = '0;
      end else if (int'(v) > size - 1) begin
         r = 9'(size - 1);
      end else begin
         r = v[8:0];
      end
      return r;
   endfunction

endpackage

### hdl/trd_ram.sv
// Generic single write port, single read port RAM with a registered read.
// No dependencies.
module trd_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### hdl/trd_unit.sv
// Shared iterative arithmetic unit: shift-add multiplier and restoring fraction divider
// built around one wide adder. Depends on trd_pkg.
module trd_unit import trd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  trd_cmd_type          cmd,
   output trd_stat_type         stat,
   output logic [WIDE-1:0]      product,
   output logic [DIV_STEPS-1:0] quotient
);

   logic [WIDE-1:0]  acc_ff, acc_in;
   logic [WIDE-1:0]  addend_ff, addend_in;
   logic [OPW-1:0]   mult_ff, mult_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             div_ff, div_in;

   logic [WIDE-1:0]  lhs, rhs;
   logic [WIDE:0]    sum;
   logic             keep;

   // In divide mode the adder subtracts the divisor from the doubled remainder.
   always_comb begin
      lhs  = div_ff ? {acc_ff[WIDE-2:0], 1'b0} : acc_ff;
      rhs  = div_ff ? ~addend_ff : (mult_ff[0] ? addend_ff : '0);
      sum  = {1'b0, lhs} + {1'b0, rhs} + (WIDE+1)'(div_ff);
      keep = div_ff && !sum[WIDE];
   end

   always_comb begin
      acc_in    = acc_ff;
      addend_in = addend_ff;
      mult_in   = mult_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      div_in    = div_ff;
      done_in   = 1'b0;
      if (cmd.go) begin
         acc_in    = cmd.acc_init;
         addend_in = cmd.addend;
         mult_in   = cmd.mult;
         div_in    = cmd.is_div;
         cnt_in    = cmd.is_div ? CNT_W'(DIV_STEPS) : CNT_W'(MUL_STEPS);
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         acc_in = keep ? lhs : sum[WIDE-1:0];
         if (div_ff) begin
            mult_in = {mult_ff[OPW-2:0], !keep};
         end else begin
            mult_in   = {1'b0, mult_ff[OPW-1:1]};
            addend_in = {addend_ff[WIDE-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      addend_ff <= addend_in;
      mult_ff   <= mult_in;
      cnt_ff    <= cnt_in;
      div_ff    <= div_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign product   = acc_ff;
   assign quotient  = mult_ff[DIV_STEPS-1:0];

endmodule

### hdl/triangle_raster_depth_test.sv
// Triangle setup and per-pixel coverage and depth test. Depends on trd_pkg, trd_unit, trd_ram.
// A vertex load on slot 0, 1 or 3 goes straight to the reply; the slot 2 load first runs two
// products for the signed area. A pixel takes at most six products for the edges, two
// divisions and three products for the depth, all on one shared adder. One transaction is
// in flight at a time. Reset is synchronous; afterwards the depth store of 262144 words is
// swept to farthest, one word a cycle, while req_tready stays low. csr writes are taken at
// any time.
module triangle_raster_depth_test import trd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic         csr_wr_data,
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata: vertex_slot[1:0], vertex_x[25:2], vertex_y[49:26], vertex_depth[73:50],
   //        pixel_x[83:74], pixel_y[93:84], zero fill above
   input  logic [95:0]  req_tdata,
   // tuser: action
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata: face_culled[0], box_min_x[9:1], box_max_x[18:10], box_min_y[27:19],
   //        box_max_y[36:28], fragment_pass[37], pixel_address[55:38],
   //        fragment_depth[79:56], weight_first[96:80], weight_second[113:97], zero fill
   output logic [119:0] rsp_tdata,
   // tuser: result_kind
   output logic         rsp_tuser
);

   typedef enum logic [8:0] {
      ST_CLEAR  = 9'b000000001,
      ST_IDLE   = 9'b000000010,
      ST_TERM_A = 9'b000000100,
      ST_TERM_B = 9'b000001000,
      ST_CHECK  = 9'b000010000,
      ST_DIVIDE = 9'b000100000,
      ST_DEPTH  = 9'b001000000,
      ST_FINISH = 9'b010000000,
      ST_REPLY  = 9'b100000000
   } trd_state_type;

   trd_state_type state_ff, state_in;

   // Input field views.
   logic [1:0]         in_slot;
   logic signed [23:0] in_vx, in_vy;
   logic [23:0]        in_vz;
   logic [9:0]         in_px, in_py;
   assign in_slot = req_tdata[1:0];
   assign in_vx   = req_tdata[25:2];
   assign in_vy   = req_tdata[49:26];
   assign in_vz   = req_tdata[73:50];
   assign in_px   = req_tdata[83:74];
   assign in_py   = req_tdata[93:84];

   logic req_fire;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // Triangle state.
   logic signed [23:0] vx_ff [3];
   logic signed [23:0] vy_ff [3];
   logic [23:0]        vz_ff [3];
   logic [WIDE-1:0]    area_ff, area_in;
   logic               culled_ff, culled_in;
   logic               cull_mode_ff;

   // Per-transaction working registers.
   logic               run_ff, run_in;
   logic [1:0]         k_ff, k_in;
   logic               setup_ff, setup_in;
   logic               kind_ff, kind_in;
   logic [9:0]         px_ff, px_in, py_ff, py_in;
   logic [17:0]        addr_ff, addr_in;
   logic signed [WIDE-1:0] term_ff, term_in;
   logic [WIDE-1:0]    wmag0_ff, wmag0_in, wmag1_ff, wmag1_in;
   logic [23:0]        b0_ff, b0_in, b1_ff, b1_in;
   logic [WIDE-1:0]    sum_ff, sum_in;
   logic [23:0]        fdepth_ff, fdepth_in;
   logic               pass_ff, pass_in;
   logic [DEPTH_AW-1:0] clear_cnt_ff, clear_cnt_in;

   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [119:0]       rsp_data_ff, rsp_data_in;
   logic               rsp_user_ff, rsp_user_in;

   // Shared unit.
   trd_cmd_type        cmd;
   trd_stat_type       unit_stat;
   logic [WIDE-1:0]    product;
   logic [DIV_STEPS-1:0] quotient;

   trd_unit u_unit (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .stat    (unit_stat),
      .product (product),
      .quotient(quotient)
   );

   // Depth store.
   logic                ram_we, ram_re;
   logic [DEPTH_AW-1:0] ram_waddr, ram_raddr;
   logic [23:0]         ram_wdata, ram_rdata;

   trd_ram #(.WIDTH(24), .DEPTH(DEPTH_WORDS)) u_depth_ram (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .re   (ram_re),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   // Pixel window test and bottom-left origin address of the incoming request.
   logic        in_window;
   logic [17:0] in_addr;
   assign in_window = (int'(in_px) < SCREEN_WIDTH) && (int'(in_py) < SCREEN_HEIGHT);
   assign in_addr   = 18'((SCREEN_HEIGHT - 1 - int'(in_py)) * SCREEN_WIDTH + int'(in_px));

   // Edge function operands. Edge k runs from vertex a to vertex b; the point is the
   // pixel centre, or vertex 2 when the signed area is computed during setup.
   logic signed [OPW-1:0] ax, ay, bx, by, qx, qy;
   logic signed [OPW-1:0] m1, m2;
   logic [OPW-1:0]        mag1, mag2;
   logic                  prod_neg;

   always_comb begin
      case (k_ff)
         2'd0: begin
            ax = OPW'(vx_ff[1]); ay = OPW'(vy_ff[1]);
            bx = OPW'(vx_ff[2]); by = OPW'(vy_ff[2]);
         end
         2'd1: begin
            ax = OPW'(vx_ff[2]); ay = OPW'(vy_ff[2]);
            bx = OPW'(vx_ff[0]); by = OPW'(vy_ff[0]);
         end
         default: begin
            ax = OPW'(vx_ff[0]); ay = OPW'(vy_ff[0]);
            bx = OPW'(vx_ff[1]); by = OPW'(vy_ff[1]);
         end
      endcase
      if (setup_ff) begin
         qx = OPW'(vx_ff[2]);
         qy = OPW'(vy_ff[2]);
      end else begin
         qx = $signed({8'd0, px_ff, HALF_PIXEL});
         qy = $signed({8'd0, py_ff, HALF_PIXEL});
      end
      if (state_ff == ST_TERM_A) begin
         m1 = bx - ax;
         m2 = qy - ay;
      end else begin
         m1 = by - ay;
         m2 = qx - ax;
      end
      mag1     = m1[OPW-1] ? OPW'(-m1) : OPW'(m1);
      mag2     = m2[OPW-1] ? OPW'(-m2) : OPW'(m2);
      prod_neg = m1[OPW-1] ^ m2[OPW-1];
   end

   // Third barycentric weight and the depth operand of the current product.
   logic [24:0] b2;
   logic [24:0] bsel;
   logic [23:0] zsel;
   assign b2 = 25'(1 << 24) - {1'b0, b0_ff} - {1'b0, b1_ff};

   always_comb begin
      case (k_ff)
         2'd0:    begin bsel = {1'b0, b0_ff}; zsel = vz_ff[0]; end
         2'd1:    begin bsel = {1'b0, b1_ff}; zsel = vz_ff[1]; end
         default: begin bsel = b2;            zsel = vz_ff[2]; end
      endcase
   end

   // Unit command.
   always_comb begin
      cmd.go       = 1'b0;
      cmd.is_div   = 1'b0;
      cmd.acc_init = '0;
      cmd.addend   = WIDE'(mag1);
      cmd.mult     = mag2;
      case (state_ff)
         ST_TERM_A, ST_TERM_B: begin
            cmd.go = !run_ff;
         end
         ST_DIVIDE: begin
            cmd.go       = !run_ff;
            cmd.is_div   = 1'b1;
            cmd.acc_init = (k_ff == 2'd0) ? wmag0_ff : wmag1_ff;
            cmd.addend   = area_ff;
            cmd.mult     = '0;
         end
         ST_DEPTH: begin
            cmd.go     = !run_ff;
            cmd.addend = WIDE'(zsel);
            cmd.mult   = OPW'(bsel);
         end
         default: begin
            cmd.go = 1'b0;
         end
      endcase
   end

   // Edge value evaluation: inside means strictly positive for the normal pass and strictly
   // negative for the shadow pass; the same test culls the triangle at setup.
   logic w_neg, w_zero, w_fail;
   logic [WIDE-1:0] w_mag;
   assign w_neg  = term_ff[WIDE-1];
   assign w_zero = (term_ff == '0);
   assign w_fail = cull_mode_ff ? !w_neg : (w_neg || w_zero);
   assign w_mag  = w_neg ? WIDE'(-term_ff) : WIDE'(term_ff);

   // Rounded depth for the compare against the stored value.
   logic [WIDE-1:0] rounded;
   logic [23:0]     new_depth;
   assign rounded   = sum_ff + WIDE'(1 << 23);
   assign new_depth = rounded[47:24];

   // Bounding box of the stored vertices.
   logic signed [23:0] mnx, mxx, mny, mxy;
   logic signed [24:0] cx_sum, cy_sum;
   logic [8:0]         box_mnx, box_mxx, box_mny, box_mxy;

   always_comb begin
      mnx = vx_ff[0]; mxx = vx_ff[0];
      mny = vy_ff[0]; mxy = vy_ff[0];
      for (int i = 1; i < 3; i++) begin
         if (vx_ff[i] < mnx) mnx = vx_ff[i];
         if (vx_ff[i] > mxx) mxx = vx_ff[i];
         if (vy_ff[i] < mny) mny = vy_ff[i];
         if (vy_ff[i] > mxy) mxy = vy_ff[i];
      end
      cx_sum  = 25'(mxx) + 25'sd255;
      cy_sum  = 25'(mxy) + 25'sd255;
      box_mnx = clamp_pix(18'(mnx >>> 8), SCREEN_WIDTH);
      box_mxx = clamp_pix(18'(cx_sum >>> 8), SCREEN_WIDTH);
      box_mny = clamp_pix(18'(mny >>> 8), SCREEN_HEIGHT);
      box_mxy = clamp_pix(18'(cy_sum >>> 8), SCREEN_HEIGHT);
   end

   // Depth store ports: the sweep after reset, the read at pixel acceptance and the
   // conditional write when the fragment is nearer.
   always_comb begin
      ram_re    = req_fire && req_tuser && in_window;
      ram_raddr = in_addr[DEPTH_AW-1:0];
      ram_we    = 1'b0;
      ram_waddr = clear_cnt_ff;
      ram_wdata = FAR_DEPTH;
      if (state_ff == ST_CLEAR) begin
         ram_we = 1'b1;
      end else if (state_ff == ST_FINISH && new_depth < ram_rdata) begin
         ram_we    = 1'b1;
         ram_waddr = addr_ff[DEPTH_AW-1:0];
         ram_wdata = new_depth;
      end
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      run_in       = run_ff;
      k_in         = k_ff;
      setup_in     = setup_ff;
      kind_in      = kind_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      addr_in      = addr_ff;
      term_in      = term_ff;
      wmag0_in     = wmag0_ff;
      wmag1_in     = wmag1_ff;
      b0_in        = b0_ff;
      b1_in        = b1_ff;
      sum_in       = sum_ff;
      fdepth_in    = fdepth_ff;
      pass_in      = pass_ff;
      area_in      = area_ff;
      culled_in    = culled_ff;
      clear_cnt_in = clear_cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.go) begin
         run_in = 1'b1;
      end

      case (state_ff)
         ST_CLEAR: begin
            clear_cnt_in = clear_cnt_ff + DEPTH_AW'(1);
            if (clear_cnt_ff == DEPTH_AW'(DEPTH_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               kind_in   = req_tuser;
               fdepth_in = '0;
               b0_in     = '0;
               b1_in     = '0;
               pass_in   = 1'b0;
               sum_in    = '0;
               k_in      = 2'd0;
               state_in  = ST_REPLY;
               if (!req_tuser) begin
                  addr_in = '0;
                  if (in_slot == 2'd2) begin
                     setup_in = 1'b1;
                     k_in     = 2'd2;
                     state_in = ST_TERM_A;
                  end else if (in_slot != 2'd3) begin
                     culled_in = 1'b1;
                  end
               end else begin
                  px_in    = in_px;
                  py_in    = in_py;
                  setup_in = 1'b0;
                  addr_in  = in_window ? in_addr[17:0] : '0;
                  if (in_window && !culled_ff) begin
                     state_in = ST_TERM_A;
                  end
               end
            end
         end
         ST_TERM_A: begin
            if (unit_stat.done) begin
               run_in   = 1'b0;
               term_in  = prod_neg ? -$signed(product) : $signed(product);
               state_in = ST_TERM_B;
            end
         end
         ST_TERM_B: begin
            if (unit_stat.done) begin
               run_in   = 1'b0;
               term_in  = prod_neg ? term_ff + $signed(product) : term_ff - $signed(product);
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (setup_ff) begin
               culled_in = w_fail;
               area_in   = w_mag;
               setup_in  = 1'b0;
               state_in  = ST_REPLY;
            end else if (w_fail) begin
               state_in = ST_REPLY;
            end else begin
               if (k_ff == 2'd0) wmag0_in = w_mag;
               if (k_ff == 2'd1) wmag1_in = w_mag;
               if (k_ff == 2'd2) begin
                  k_in     = 2'd0;
                  state_in = ST_DIVIDE;
               end else begin
                  k_in     = k_ff + 2'd1;
                  state_in = ST_TERM_A;
               end
            end
         end
         ST_DIVIDE: begin
            if (unit_stat.done) begin
               run_in = 1'b0;
               if (k_ff == 2'd0) begin
                  b0_in = quotient;
                  k_in  = 2'd1;
               end else begin
                  b1_in    = quotient;
                  k_in     = 2'd0;
                  state_in = ST_DEPTH;
               end
            end
         end
         ST_DEPTH: begin
            if (unit_stat.done) begin
               run_in = 1'b0;
               sum_in = sum_ff + product;
               if (k_ff == 2'd2) begin
                  state_in = ST_FINISH;
               end else begin
                  k_in = k_ff + 2'd1;
               end
            end
         end
         ST_FINISH: begin
            fdepth_in = new_depth;
            pass_in   = (new_depth < ram_rdata);
            state_in  = ST_REPLY;
         end
         ST_REPLY: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = kind_ff;
               rsp_data_in  = {6'd0,
                               {1'b0, b1_ff[23:8]},
                               {1'b0, b0_ff[23:8]},
                               fdepth_ff,
                               addr_ff,
                               pass_ff,
                               kind_ff ? 9'd0 : box_mxy,
                               kind_ff ? 9'd0 : box_mny,
                               kind_ff ? 9'd0 : box_mxx,
                               kind_ff ? 9'd0 : box_mnx,
                               culled_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      setup_ff    <= setup_in;
      kind_ff     <= kind_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      addr_ff     <= addr_in;
      term_ff     <= term_in;
      wmag0_ff    <= wmag0_in;
      wmag1_ff    <= wmag1_in;
      b0_ff       <= b0_in;
      b1_ff       <= b1_in;
      sum_ff      <= sum_in;
      fdepth_ff   <= fdepth_in;
      pass_ff     <= pass_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         run_ff       <= 1'b0;
         clear_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
         cull_mode_ff <= 1'b0;
         culled_ff    <= 1'b1;
         area_ff      <= '0;
         for (int i = 0; i < 3; i++) begin
            vx_ff[i] <= '0;
            vy_ff[i] <= '0;
            vz_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         run_ff       <= run_in;
         clear_cnt_ff <= clear_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         culled_ff    <= culled_in;
         area_ff      <= area_in;
         if (csr_wr_en) begin
            cull_mode_ff <= csr_wr_data;
         end
         // A vertex transaction on slot 3 stores nothing.
         if (req_fire && !req_tuser) begin
            for (int i = 0; i < 3; i++) begin
               if (in_slot == 2'(i)) begin
                  vx_ff[i] <= in_vx;
                  vy_ff[i] <= in_vy;
                  vz_ff[i] <= in_vz;
               end
            end
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // The sweep of the depth store must finish before any transaction is taken.
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_tready)
      else $error("transaction accepted during depth store sweep");

   // The shared unit only finishes an operation that the sequencer started.
   a_done_when_run: assert property (@(posedge clock) disable iff (reset)
      unit_stat.done |-> run_ff)
      else $error("shared unit finished without a pending operation");

   // Depth writes outside the sweep happen only at the final compare.
   a_write_in_finish: assert property (@(posedge clock) disable iff (reset)
      (ram_we && state_ff != ST_CLEAR) |-> (state_ff == ST_FINISH))
      else $error("depth store written outside the compare step");

   // A passing fragment never comes from a culled triangle.
   a_pass_not_culled: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser && rsp_tdata[37]) |-> !rsp_tdata[0])
      else $error("fragment passed on a culled triangle");

endmodule
